// ===== hdl/frd_pkg.sv =====
`default_nettype none

package frd_pkg;

  // Parser phases
  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_LEADER  = 3'd1;
  localparam logic [2:0] PH_VALUES  = 3'd2;
  localparam logic [2:0] PH_TRAILER = 3'd3;
  localparam logic [2:0] PH_IDLE    = 3'd4;

  // Record kinds
  localparam logic [1:0] KIND_INT  = 2'd0;
  localparam logic [1:0] KIND_FLT  = 2'd1;
  localparam logic [1:0] KIND_DBL  = 2'd2;
  localparam logic [1:0] KIND_LOGI = 2'd3;

  // Result kinds
  localparam logic [1:0] RES_ELEMENT = 2'd0;
  localparam logic [1:0] RES_DONE    = 2'd1;
  localparam logic [1:0] RES_ERROR   = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_MISMATCH = 2'd1;
  localparam logic [1:0] ERR_BAD_LEN  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_KIND  = 2'd0;
  localparam logic [1:0] CFG_COUNT = 2'd1;
  localparam logic [1:0] CFG_SWAP  = 2'd2;

  localparam int unsigned CFG_DATA_W = 31;

  // One classified result travelling from the parser to the formatter
  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  code;
    logic        last;
    logic [1:0]  kind;
    logic        swap;
    logic [31:0] word_a;  // first half of a double, raw
    logic [31:0] word_b;  // current word, raw
  } frd_cmd_t;

  function automatic logic [31:0] bswap32(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/frd_front.sv =====
`default_nettype none

module frd_front #(
  parameter int unsigned HEADER_WORDS = 6
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  [31:0]           file_word,
  input  wire                   start_record,
  input  wire  [1:0]            record_kind,
  input  wire  [30:0]           element_count,
  input  wire                   swap_bytes,
  input  wire                   queue_full,
  output logic                  push,
  output frd_pkg::frd_cmd_t     cmd
);
  import frd_pkg::*;

  logic [2:0]  phase, phase_next;
  logic [2:0]  hdr_seen, hdr_seen_next;
  logic [31:0] block_marker, block_marker_next;
  logic [30:0] block_left, block_left_next;
  logic [30:0] rec_left, rec_left_next;
  logic [31:0] first_half, first_half_next;
  logic        half_pending, half_pending_next;

  logic        accept;
  logic [31:0] w;
  logic [2:0]  ph;
  logic [2:0]  hs1;
  logic [30:0] cnt;
  logic [30:0] block_dec;
  logic [30:0] rec_dec;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign w        = swap_bytes ? bswap32(file_word) : file_word;

  always_comb begin
    phase_next        = phase;
    hdr_seen_next     = hdr_seen;
    block_marker_next = block_marker;
    block_left_next   = block_left;
    rec_left_next     = rec_left;
    first_half_next   = first_half;
    half_pending_next = half_pending;
    push              = 1'b0;
    cmd.op            = RES_ELEMENT;
    cmd.code          = ERR_NONE;
    cmd.last          = 1'b0;
    cmd.kind          = record_kind;
    cmd.swap          = swap_bytes;
    cmd.word_a        = first_half;
    cmd.word_b        = file_word;
    ph                = phase;
    hs1               = 3'd0;
    cnt               = 31'd0;
    block_dec         = 31'd0;
    rec_dec           = 31'd0;

    if (accept) begin
      // A start word abandons whatever record was in flight
      if (start_record) begin
        rec_left_next     = element_count;
        hdr_seen_next     = 3'd0;
        block_left_next   = 31'd0;
        half_pending_next = 1'b0;
        first_half_next   = 32'd0;
        ph                = (HEADER_WORDS == 0) ? PH_LEADER : PH_HEADER;
      end

      if (start_record && HEADER_WORDS == 0 && element_count == 31'd0) begin
        phase_next = PH_IDLE;
        push       = 1'b1;
        cmd.op     = RES_DONE;
      end else begin
        phase_next = ph;
        case (ph)
          PH_HEADER: begin
            hs1 = hdr_seen_next + 3'd1;
            if ({1'b0, hs1} >= 4'(HEADER_WORDS)) begin
              hdr_seen_next = 3'd0;
              if (rec_left_next == 31'd0) begin
                phase_next = PH_IDLE;
                push       = 1'b1;
                cmd.op     = RES_DONE;
              end else begin
                phase_next = PH_LEADER;
              end
            end else begin
              hdr_seen_next = hs1;
            end
          end
          PH_LEADER: begin
            block_marker_next = w;
            if (w[31]) begin
              cnt = 31'd0;
            end else if (record_kind == KIND_DBL) begin
              cnt = {3'd0, w[30:3]};
            end else begin
              cnt = {2'd0, w[30:2]};
            end
            if (cnt == 31'd0) begin
              phase_next = PH_IDLE;
              push       = 1'b1;
              cmd.op     = RES_ERROR;
              cmd.code   = ERR_BAD_LEN;
            end else begin
              block_left_next   = (cnt < rec_left_next) ? cnt : rec_left_next;
              half_pending_next = 1'b0;
              phase_next        = PH_VALUES;
            end
          end
          PH_VALUES: begin
            if (record_kind == KIND_DBL && !half_pending) begin
              first_half_next   = file_word;
              half_pending_next = 1'b1;
            end else begin
              half_pending_next = 1'b0;
              block_dec = (block_left != 31'd0) ? block_left - 31'd1 : block_left;
              rec_dec   = (rec_left != 31'd0) ? rec_left - 31'd1 : rec_left;
              block_left_next = block_dec;
              rec_left_next   = rec_dec;
              push     = 1'b1;
              cmd.last = (rec_dec == 31'd0);
              if (block_dec == 31'd0) begin
                phase_next = PH_TRAILER;
              end
            end
          end
          PH_TRAILER: begin
            if (w != block_marker) begin
              phase_next = PH_IDLE;
              push       = 1'b1;
              cmd.op     = RES_ERROR;
              cmd.code   = ERR_MISMATCH;
            end else if (rec_left == 31'd0) begin
              phase_next = PH_IDLE;
              push       = 1'b1;
              cmd.op     = RES_DONE;
            end else begin
              phase_next = PH_LEADER;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      hdr_seen     <= 3'd0;
      block_marker <= 32'd0;
      block_left   <= 31'd0;
      rec_left     <= 31'd0;
      first_half   <= 32'd0;
      half_pending <= 1'b0;
    end else begin
      phase        <= phase_next;
      hdr_seen     <= hdr_seen_next;
      block_marker <= block_marker_next;
      block_left   <= block_left_next;
      rec_left     <= rec_left_next;
      first_half   <= first_half_next;
      half_pending <= half_pending_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/frd_queue.sv =====
`default_nettype none

module frd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  frd_pkg::frd_cmd_t  push_cmd,
  output logic               full,
  output logic               q_valid,
  output frd_pkg::frd_cmd_t  q_cmd,
  input  wire                pop
);
  import frd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  frd_cmd_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign q_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + CNT_W'(1))
    else $error("queue count did not advance on push");
`endif

endmodule

`default_nettype wire

// ===== hdl/frd_back.sv =====
`default_nettype none

module frd_back (
  input  wire                clk,
  input  wire                rst,
  input  wire                q_valid,
  input  frd_pkg::frd_cmd_t  q_cmd,
  output logic               pop,
  output logic               out_valid,
  input  wire                out_ready,
  output logic [63:0]        value_bits,
  output logic [1:0]         result_kind,
  output logic               last_element,
  output logic [1:0]         error_code
);
  import frd_pkg::*;

  logic [31:0] w;
  logic [31:0] neg;
  logic [63:0] val;

  assign pop = q_valid && (!out_valid || out_ready);
  assign w   = q_cmd.swap ? bswap32(q_cmd.word_b) : q_cmd.word_b;
  assign neg = 32'd0 - w;

  always_comb begin
    val = 64'd0;
    if (q_cmd.op == RES_ELEMENT) begin
      case (q_cmd.kind)
        KIND_DBL: begin
          if (q_cmd.swap) begin
            val = {bswap32(q_cmd.word_a), bswap32(q_cmd.word_b)};
          end else begin
            val = {q_cmd.word_b, q_cmd.word_a};
          end
        end
        KIND_FLT:  val = {32'd0, w};
        KIND_LOGI: val = {{32{neg[31]}}, neg};
        default:   val = {{32{w[31]}}, w};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      value_bits   <= val;
      result_kind  <= q_cmd.op;
      last_element <= q_cmd.last;
      error_code   <= q_cmd.code;
    end
  end

`ifndef ASSERT_OFF
  a_status_zero_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != RES_ELEMENT |-> value_bits == 64'd0)
    else $error("status result carries value bits");
  a_error_has_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == RES_ERROR |-> error_code != ERR_NONE)
    else $error("error result without code");
  a_last_only_elem: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_element |-> result_kind == RES_ELEMENT)
    else $error("last flag on status result");
`endif

endmodule

`default_nettype wire

// ===== hdl/fortran_record_deframer.sv =====
// Channel   | Signals                                          | Dir | Handshake
// ----------+--------------------------------------------------+-----+-----------------
// input     | file_word, start_record                          | in  | in_valid/in_ready
// output    | value_bits, result_kind, last_element, error_code| out | out_valid/out_ready
// config    | cfg_index, cfg_data                              | in  | cfg_write
//
// One file word is taken per cycle while in_ready is high; a word yields at most one result.
// The accepting edge writes the word's result into the queue; the formatter's output
// register loads it when popped. Results leave one per cycle while out_ready is high.
// Reset (rst, synchronous) puts the parser in header skip with nothing outstanding.
// in_ready drops only while the result queue is full, which takes an out_ready stall;
// after the stall, in_ready returns once a pop has freed a slot in the queue.
`default_nettype none

module fortran_record_deframer #(
  parameter int unsigned HEADER_WORDS = 6,
  parameter int unsigned QUEUE_DEPTH  = 4
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            cfg_write,
  input  wire  [1:0]                     cfg_index,
  input  wire  [frd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire  [31:0]                    file_word,
  input  wire                            start_record,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [63:0]                    value_bits,
  output logic [1:0]                     result_kind,
  output logic                           last_element,
  output logic [1:0]                     error_code
);
  import frd_pkg::*;

  // Configuration registers; the user must write them only while the block is quiet, the block does not enforce it
  logic [1:0]  record_kind;
  logic [30:0] element_count;
  logic        swap_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      record_kind   <= KIND_INT;
      element_count <= 31'd1;
      swap_bytes    <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_KIND:  record_kind   <= cfg_data[1:0];
        CFG_COUNT: element_count <= cfg_data[30:0];
        CFG_SWAP:  swap_bytes    <= cfg_data[0];
        default:   ;
      endcase
    end
  end

  // Parser -> queue -> formatter
  logic     push;
  frd_cmd_t push_cmd;
  logic     queue_full;
  logic     q_valid;
  frd_cmd_t q_cmd;
  logic     pop;

  // Front: walk header, leader, values and trailer; classify each word
  frd_front #(
    .HEADER_WORDS (HEADER_WORDS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .file_word     (file_word),
    .start_record  (start_record),
    .record_kind   (record_kind),
    .element_count (element_count),
    .swap_bytes    (swap_bytes),
    .queue_full    (queue_full),
    .push          (push),
    .cmd           (push_cmd)
  );

  // Hold classified transactions so each side stalls on its own
  frd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop)
  );

  // Back: byte swap, assemble doubles, negate logicals, sign extend integers, zero extend floats, register out
  frd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .value_bits   (value_bits),
    .result_kind  (result_kind),
    .last_element (last_element),
    .error_code   (error_code)
  );

endmodule

`default_nettype wire
